/* hw/rtl/texture_column_mapper_top_assert.svh */
// Assertion macros for the texture column mapper.
// Bodies expect clk and arst_n in the including scope; ASSERT_OFF empties them.
`ifndef TEXTURE_COLUMN_MAPPER_TOP_ASSERT_SVH
`define TEXTURE_COLUMN_MAPPER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define TCM_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
`define TCM_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define TCM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TCM_ASSERT_ALWAYS(lbl, expr, msg)
`define TCM_ASSERT_IMPL(lbl, ante, cons, msg)
`define TCM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* hw/rtl/tcm_pkg.sv */
// Shared types and constants of the texture column mapper.
// No dependencies; every module refers to it by scoped names.
package tcm_pkg;

	localparam int TEX_DEPTH_DEF      = 65536;
	localparam int DEST_ADDR_BITS_DEF = 24;
	localparam int SHADE_DEPTH        = 256;
	localparam int BLEND_DEPTH        = 65536;
	localparam int OUT_ADDR_W         = 24;
	localparam int KEY_W              = 32;
	// pixel results that may be in flight or queued at once
	localparam int CREDITS            = 16;

	localparam logic [7:0] TRANSPARENT_TEXEL = 8'd255;

	localparam logic [1:0] MODE_OPAQUE = 2'd0;

	typedef enum logic [2:0] {
		CMD_START      = 3'd0,
		CMD_PIXEL      = 3'd1,
		CMD_LOAD_TEX   = 3'd2,
		CMD_LOAD_SHADE = 3'd3,
		CMD_LOAD_BLEND = 3'd4
	} tcm_cmd_e;

	typedef enum logic [2:0] {
		REG_TEXEL_SHIFT   = 3'd0,
		REG_DRAW_MODE     = 3'd1,
		REG_ROW_STRIDE    = 3'd2,
		REG_BLEND_ENABLE  = 3'd3,
		REG_BLEND_REVERSE = 3'd4
	} tcm_reg_e;

	typedef struct packed {
		logic [2:0]         cmd;
		logic [23:0]        addr;
		logic [7:0]         data;
		logic [31:0]        pos;
		logic signed [31:0] step;
		logic [7:0]         dest_pixel;
		logic               final_pixel;
	} tcm_in_t;

	typedef struct packed {
		logic        write_enable;
		logic [23:0] dest_addr;
		logic [7:0]  color;
		logic [31:0] next_pos;
		logic        column_done;
	} tcm_out_t;

	// one transaction travelling down the table pipeline
	typedef struct packed {
		logic        pix;
		logic        ld_tex;
		logic        ld_shade;
		logic        ld_blend;
		logic [23:0] addr;
		logic [7:0]  data;
		logic [7:0]  dpix;
		logic        fin;
		logic [23:0] dest;
		logic [31:0] npos;
	} tcm_op_t;

endpackage

/* hw/rtl/tcm_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies beyond tcm_pkg defaults.
module tcm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = tcm_pkg::SHADE_DEPTH
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/tcm_index.sv */
// Texture index unit: key modulo TEX_DEPTH, payload delayed alongside.
// Depends on tcm_pkg. One stage for a power-of-two depth, three otherwise.
module tcm_index #(
	parameter int TEX_DEPTH = tcm_pkg::TEX_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [tcm_pkg::KEY_W-1:0]    key,
	input  tcm_pkg::tcm_op_t             op_in,
	output logic [$clog2(TEX_DEPTH)-1:0] idx,
	output tcm_pkg::tcm_op_t             op_out
);

	localparam int TEX_AW = $clog2(TEX_DEPTH);

	if ((TEX_DEPTH & (TEX_DEPTH - 1)) == 0) begin : g_pow2
		logic [TEX_AW-1:0] idx_s1;
		tcm_pkg::tcm_op_t  op_s1;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				op_s1 <= '0;
			end else begin
				op_s1 <= op_in;
			end
		end

		always_ff @(posedge clk) begin
			idx_s1 <= key[TEX_AW-1:0];
		end

		assign idx    = idx_s1;
		assign op_out = op_s1;
	end else begin : g_recip
		// quotient estimate floor(key * floor(2^40/D) / 2^40) is q or q-1,
		// so one conditional subtract finishes the remainder
		localparam logic [63:0] RECIP64 = (64'd1 << 40) / 64'(TEX_DEPTH);
		localparam logic [31:0] RECIP   = RECIP64[31:0];
		localparam logic [24:0] DIVC    = 25'(TEX_DEPTH);
		localparam logic [TEX_AW:0] DIVR = (TEX_AW + 1)'(TEX_DEPTH);

		logic [63:0]       prod;
		logic [48:0]       qd;
		logic [31:0]       rem;
		logic [23:0]       quo_s1;
		logic [31:0]       key_s1;
		logic [TEX_AW:0]   rem_s2;
		logic [TEX_AW-1:0] idx_s3;
		tcm_pkg::tcm_op_t  op_s1;
		tcm_pkg::tcm_op_t  op_s2;
		tcm_pkg::tcm_op_t  op_s3;

		assign prod = {32'd0, key} * {32'd0, RECIP};
		assign qd   = 49'(quo_s1) * 49'(DIVC);
		assign rem  = key_s1 - qd[31:0];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				op_s1 <= '0;
				op_s2 <= '0;
				op_s3 <= '0;
			end else begin
				op_s1 <= op_in;
				op_s2 <= op_s1;
				op_s3 <= op_s2;
			end
		end

		always_ff @(posedge clk) begin
			quo_s1 <= prod[63:40];
			key_s1 <= key;
			rem_s2 <= rem[TEX_AW:0];
			if (rem_s2 >= DIVR) begin
				idx_s3 <= TEX_AW'(rem_s2 - DIVR);
			end else begin
				idx_s3 <= TEX_AW'(rem_s2);
			end
		end

		assign idx    = idx_s3;
		assign op_out = op_s3;
	end

endmodule

/* hw/rtl/tcm_outq.sv */
// Result queue between the table pipeline and the output channel.
// Depends on tcm_pkg. Overflow is prevented upstream by credit counting.
module tcm_outq #(
	parameter int DEPTH = tcm_pkg::CREDITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tcm_pkg::tcm_out_t push_data,
	output logic              valid,
	input  logic              stall,
	output tcm_pkg::tcm_out_t data
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	tcm_pkg::tcm_out_t store [DEPTH];
	logic [PW-1:0]     wr_q;
	logic [PW-1:0]     rd_q;
	logic [CW-1:0]     cnt_q;
	logic              pop;

	assign valid = (cnt_q != '0);
	assign pop   = valid && !stall;
	assign data  = store[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			store[wr_q] <= push_data;
		end
	end

endmodule

/* hw/rtl/texture_column_mapper_top.sv */
// Texture column mapper. Throughput: one transaction per cycle on each side,
// unless that side is stalled. Path: index (modulo via a reciprocal multiply
// when TEX_DEPTH is not a power of two), texture, shade, blend, result queue.
// Input stalls only when 16 pixel results are outstanding (queue credit).
// Reset: registers to their defaults, position/step/address to zero; the
// texture, shade and blend tables are not cleared and need no clearing pass.
`include "texture_column_mapper_top_assert.svh"

module texture_column_mapper_top #(
	parameter int TEX_DEPTH      = tcm_pkg::TEX_DEPTH_DEF,
	parameter int DEST_ADDR_BITS = tcm_pkg::DEST_ADDR_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// input channel
	input  logic              in_valid,
	output logic              in_stall,
	input  tcm_pkg::tcm_in_t  in_data,
	// result channel
	output logic              out_valid,
	input  logic              out_stall,
	output tcm_pkg::tcm_out_t out_data,
	// configuration writes
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_wdata
);

	localparam int TEX_AW = $clog2(TEX_DEPTH);
	localparam int CNT_W  = $clog2(tcm_pkg::CREDITS + 1);

	// ------------------------------------------------------------------
	// Configuration registers: user writes only while block is idle; unenforced
	// ------------------------------------------------------------------
	logic [4:0]  texel_shift_q;
	logic [1:0]  draw_mode_q;
	logic [15:0] row_stride_q;
	logic        blend_en_q;
	logic        blend_rev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			texel_shift_q <= 5'd16;
			draw_mode_q   <= tcm_pkg::MODE_OPAQUE;
			row_stride_q  <= 16'd320;
			blend_en_q    <= 1'b0;
			blend_rev_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tcm_pkg::REG_TEXEL_SHIFT:   texel_shift_q <= cfg_wdata[4:0];
				tcm_pkg::REG_DRAW_MODE:     draw_mode_q   <= cfg_wdata[1:0];
				tcm_pkg::REG_ROW_STRIDE:    row_stride_q  <= cfg_wdata;
				tcm_pkg::REG_BLEND_ENABLE:  blend_en_q    <= cfg_wdata[0];
				tcm_pkg::REG_BLEND_REVERSE: blend_rev_q   <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Input side: command decode, column walker state, credit count
	// ------------------------------------------------------------------
	logic                      in_acc;
	logic                      pix_acc;
	logic                      out_acc;
	logic [CNT_W-1:0]          cnt_q;
	logic [31:0]               pos_q;
	logic [31:0]               step_q;
	logic [DEST_ADDR_BITS-1:0] dest_q;
	logic [31:0]               npos;
	logic [31:0]               key;
	tcm_pkg::tcm_op_t          op_in;

	// credit check uses registered state only, so stall never waits on out_stall
	assign in_stall = (cnt_q == CNT_W'(tcm_pkg::CREDITS));
	assign in_acc   = in_valid && !in_stall;
	assign pix_acc  = in_acc && (in_data.cmd == tcm_pkg::CMD_PIXEL);
	assign out_acc  = out_valid && !out_stall;
	assign npos     = pos_q + step_q;

	// start addresses for loads: texel load shares the modulo path with pixels
	assign key = (in_data.cmd == tcm_pkg::CMD_PIXEL) ? (pos_q >> texel_shift_q)
		: {8'd0, in_data.addr};

	always_comb begin
		op_in      = '0;
		op_in.addr = in_data.addr;
		op_in.data = in_data.data;
		op_in.dpix = in_data.dest_pixel;
		op_in.fin  = in_data.final_pixel;
		op_in.dest = tcm_pkg::OUT_ADDR_W'(dest_q);
		op_in.npos = npos;
		if (in_acc) begin
			unique case (in_data.cmd)
				tcm_pkg::CMD_PIXEL:      op_in.pix      = 1'b1;
				tcm_pkg::CMD_LOAD_TEX:   op_in.ld_tex   = 1'b1;
				tcm_pkg::CMD_LOAD_SHADE: op_in.ld_shade = 1'b1;
				tcm_pkg::CMD_LOAD_BLEND: op_in.ld_blend = 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			step_q <= '0;
			dest_q <= '0;
		end else if (in_acc && (in_data.cmd == tcm_pkg::CMD_START)) begin
			pos_q  <= in_data.pos;
			step_q <= in_data.step;
			dest_q <= DEST_ADDR_BITS'(in_data.addr);
		end else if (pix_acc) begin
			pos_q  <= npos;
			dest_q <= dest_q + DEST_ADDR_BITS'(row_stride_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (pix_acc && !out_acc) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end else if (out_acc && !pix_acc) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// ------------------------------------------------------------------
	// Texture index: (position >> shift) or load address, modulo TEX_DEPTH
	// ------------------------------------------------------------------
	logic [TEX_AW-1:0] tex_idx;
	tcm_pkg::tcm_op_t  op_t0;

	tcm_index #(
		.TEX_DEPTH(TEX_DEPTH)
	) u_index (
		.clk    (clk),
		.arst_n (arst_n),
		.key    (key),
		.op_in  (op_in),
		.idx    (tex_idx),
		.op_out (op_t0)
	);

	// ------------------------------------------------------------------
	// Table pipeline. Each table is written and read at the same stage, so
	// loads and pixel reads of one table stay in transaction order and no
	// forwarding is needed.
	// ------------------------------------------------------------------
	logic [7:0]       tex_rdata;
	logic [7:0]       shade_rdata;
	logic [7:0]       blend_rdata;
	logic [15:0]      blend_raddr;
	logic             skip_s1;
	logic             skip_s2;
	logic             skip_s3;
	logic [7:0]       src_s3;
	tcm_pkg::tcm_op_t op_s1;
	tcm_pkg::tcm_op_t op_s2;
	tcm_pkg::tcm_op_t op_s3;
	tcm_pkg::tcm_out_t res;

	tcm_ram #(
		.WIDTH (8),
		.DEPTH (TEX_DEPTH)
	) u_tex_ram (
		.clk   (clk),
		.we    (op_t0.ld_tex),
		.waddr (tex_idx),
		.wdata (op_t0.data),
		.re    (op_t0.pix),
		.raddr (tex_idx),
		.rdata (tex_rdata)
	);

	// s1: texel available; transparent test, shade lookup
	assign skip_s1 = (draw_mode_q != tcm_pkg::MODE_OPAQUE)
		&& (tex_rdata == tcm_pkg::TRANSPARENT_TEXEL);

	tcm_ram #(
		.WIDTH (8),
		.DEPTH (tcm_pkg::SHADE_DEPTH)
	) u_shade_ram (
		.clk   (clk),
		.we    (op_s1.ld_shade),
		.waddr (op_s1.addr[7:0]),
		.wdata (op_s1.data),
		.re    (op_s1.pix),
		.raddr (tex_rdata),
		.rdata (shade_rdata)
	);

	// s2: shaded color available; blend lookup source-high or dest-high
	assign blend_raddr = blend_rev_q ? {op_s2.dpix, shade_rdata}
		: {shade_rdata, op_s2.dpix};

	tcm_ram #(
		.WIDTH (8),
		.DEPTH (tcm_pkg::BLEND_DEPTH)
	) u_blend_ram (
		.clk   (clk),
		.we    (op_s2.ld_blend),
		.waddr (op_s2.addr[15:0]),
		.wdata (op_s2.data),
		.re    (op_s2.pix),
		.raddr (blend_raddr),
		.rdata (blend_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= '0;
			op_s2 <= '0;
			op_s3 <= '0;
		end else begin
			op_s1 <= op_t0;
			op_s2 <= op_s1;
			op_s3 <= op_s2;
		end
	end

	always_ff @(posedge clk) begin
		skip_s2 <= skip_s1;
		skip_s3 <= skip_s2;
		src_s3  <= shade_rdata;
	end

	// s3: pick the color; mode 3 acts as translucent, hence draw_mode bit 1
	always_comb begin
		res.write_enable = !skip_s3;
		res.dest_addr    = op_s3.dest;
		res.next_pos     = op_s3.npos;
		res.column_done  = op_s3.fin;
		if (skip_s3) begin
			res.color = 8'd0;
		end else if (draw_mode_q[1] && blend_en_q) begin
			res.color = blend_rdata;
		end else begin
			res.color = src_s3;
		end
	end

	tcm_outq #(
		.DEPTH (tcm_pkg::CREDITS)
	) u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (op_s3.pix),
		.push_data (res),
		.valid     (out_valid),
		.stall     (out_stall),
		.data      (out_data)
	);

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`TCM_ASSERT_ALWAYS(a_credit_bound, cnt_q <= CNT_W'(tcm_pkg::CREDITS), "credit overflow")
	`TCM_ASSERT_IMPL(a_result_has_credit, out_valid, cnt_q != '0, "result without credit")
	`TCM_ASSERT_IMPL(a_skip_color, out_valid && !out_data.write_enable, out_data.color == 8'd0, "skipped pixel carries color")
	`TCM_ASSERT_NEXT(a_credit_take, pix_acc && !out_acc, cnt_q == $past(cnt_q) + CNT_W'(1), "pixel not counted")

endmodule
